// ===== rtl/tccc_pkg.sv =====
package tccc_pkg;

  // Largest supported image side and the widths that follow from it.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
  localparam int CNT_W   = $clog2(MAX_DIM);       // column and row positions

  localparam int NUM_CH   = 4;
  localparam int COMP_W   = 8;
  localparam int CLASS_W  = 3;
  localparam int CHCNT_W  = 3;

  // Border skipping applies only at or above this size on both sides.
  localparam int EDGE_MIN_SIZE = 32;
  localparam int EDGE_PAD      = 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIX_ALPHA_EDGES = 3'd3;

  // Content class codes.
  localparam logic [CLASS_W-1:0] CLS_SOLID0  = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_SOLID1  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BINARY  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_SOLID   = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_VARYING = 3'd4;

  localparam logic [COMP_W-1:0] COMP_MIN = '0;
  localparam logic [COMP_W-1:0] COMP_MAX = '1;

  // Stream word widths.
  localparam int IN_DATA_W  = NUM_CH * COMP_W;
  localparam int OUT_BITS   = NUM_CH * (CLASS_W + COMP_W);
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [CHCNT_W-1:0] chan_count;
    logic               fix_alpha_edges;
  } cfg_t;

  typedef logic [NUM_CH-1:0][COMP_W-1:0] pixel_t;

  typedef struct packed {
    logic [NUM_CH-1:0][COMP_W-1:0]  solid;
    logic [NUM_CH-1:0][CLASS_W-1:0] cls;
  } result_t;

  // Defaults for a channel that is not in use: black, opaque alpha.
  function automatic logic [CLASS_W-1:0] default_class(input int ch);
    return (ch == NUM_CH - 1) ? CLS_SOLID1 : CLS_SOLID0;
  endfunction

  function automatic logic [COMP_W-1:0] default_solid(input int ch);
    return (ch == NUM_CH - 1) ? COMP_MAX : COMP_MIN;
  endfunction

endpackage

// ===== rtl/tccc_stats.sv =====
module tccc_stats (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  tccc_pkg::pixel_t pixel,
  input  tccc_pkg::cfg_t   cfg,
  output logic             is_last,
  output tccc_pkg::result_t result
);
  import tccc_pkg::*;

  logic [NUM_CH-1:0] zero_seen, full_seen, middle_seen, differs_seen;
  logic [NUM_CH-1:0] zero_seen_next, full_seen_next, middle_seen_next, differs_seen_next;
  pixel_t            reference_pixel, reference_pixel_next;
  logic              reference_taken, reference_taken_next;
  logic [CNT_W-1:0]  column_count, row_count;

  logic [DIM_W-1:0]   w_eff, h_eff, col_inc, row_inc;
  logic [CHCNT_W-1:0] n_eff;
  logic               pad, row_end, counted;

  // Clamp the size and channel registers into their legal ranges.
  always_comb begin
    if (cfg.image_width == '0) w_eff = DIM_W'(1);
    else if (cfg.image_width > DIM_W'(MAX_DIM)) w_eff = DIM_W'(MAX_DIM);
    else w_eff = cfg.image_width;

    if (cfg.image_height == '0) h_eff = DIM_W'(1);
    else if (cfg.image_height > DIM_W'(MAX_DIM)) h_eff = DIM_W'(MAX_DIM);
    else h_eff = cfg.image_height;

    if (cfg.chan_count == '0) n_eff = CHCNT_W'(1);
    else if (cfg.chan_count > CHCNT_W'(NUM_CH)) n_eff = CHCNT_W'(NUM_CH);
    else n_eff = cfg.chan_count;
  end

  assign col_inc = DIM_W'(column_count) + DIM_W'(EDGE_PAD);
  assign row_inc = DIM_W'(row_count) + DIM_W'(EDGE_PAD);
  assign row_end = col_inc >= w_eff;
  assign is_last = row_end && (row_inc >= h_eff);

  assign pad = (n_eff == CHCNT_W'(NUM_CH)) && cfg.fix_alpha_edges &&
               (w_eff >= DIM_W'(EDGE_MIN_SIZE)) && (h_eff >= DIM_W'(EDGE_MIN_SIZE));

  assign counted = !pad || !((DIM_W'(column_count) < DIM_W'(EDGE_PAD)) ||
                             (DIM_W'(row_count) < DIM_W'(EDGE_PAD)) ||
                             row_end || (row_inc >= h_eff));

  // The first counted pixel becomes the reference and is compared with itself.
  always_comb begin
    reference_taken_next = reference_taken | counted;
    reference_pixel_next = (counted && !reference_taken) ? pixel : reference_pixel;
    zero_seen_next       = zero_seen;
    full_seen_next       = full_seen;
    middle_seen_next     = middle_seen;
    differs_seen_next    = differs_seen;
    for (int i = 0; i < NUM_CH; i++) begin
      if (counted && (CHCNT_W'(i) < n_eff)) begin
        if (pixel[i] == COMP_MIN) zero_seen_next[i] = 1'b1;
        else if (pixel[i] == COMP_MAX) full_seen_next[i] = 1'b1;
        else middle_seen_next[i] = 1'b1;
        if (pixel[i] != reference_pixel_next[i]) differs_seen_next[i] = 1'b1;
      end
    end
  end

  // Classification from the state as it stands after this pixel.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      result.cls[i]   = default_class(i);
      result.solid[i] = default_solid(i);
      if ((CHCNT_W'(i) < n_eff) && reference_taken_next) begin
        result.solid[i] = reference_pixel_next[i];
        if (middle_seen_next[i])
          result.cls[i] = differs_seen_next[i] ? CLS_VARYING : CLS_SOLID;
        else if (zero_seen_next[i] && full_seen_next[i])
          result.cls[i] = CLS_BINARY;
        else if (zero_seen_next[i])
          result.cls[i] = CLS_SOLID0;
        else if (full_seen_next[i])
          result.cls[i] = CLS_SOLID1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && is_last)) begin
      zero_seen       <= '0;
      full_seen       <= '0;
      middle_seen     <= '0;
      differs_seen    <= '0;
      reference_pixel <= '0;
      reference_taken <= 1'b0;
      column_count    <= '0;
      row_count       <= '0;
    end else if (advance) begin
      zero_seen       <= zero_seen_next;
      full_seen       <= full_seen_next;
      middle_seen     <= middle_seen_next;
      differs_seen    <= differs_seen_next;
      reference_pixel <= reference_pixel_next;
      reference_taken <= reference_taken_next;
      if (row_end) begin
        column_count <= '0;
        row_count    <= row_inc[CNT_W-1:0];
      end else begin
        column_count <= col_inc[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/texture_channel_content_classifier.sv =====
// Texture channel content classifier.
//
// Pixels enter on the slave stream, one word per pixel in raster order, with
// component 0 in the lowest byte. Channels at or above the configured channel
// count are ignored. When the last pixel of an image (width by height) has
// been taken, one word leaves on the master stream with a content class and a
// solid color for every channel; all other pixels produce nothing.
//
// Throughput is one pixel per cycle while the input is not stalled: the only
// per-pixel work is a handful of byte compares and flag updates between the
// input register and the result register. The last pixel of an image passes
// through the input register before its result word enters the result register.
//
// The result register decouples the two sides. Ordinary pixels keep flowing
// while a result waits; only a last pixel that finds the result register
// still occupied and not being taken holds in the input register, stalling the input.
//
// Synchronous reset clears the image statistics and both registers and loads
// the configuration defaults (1x1 image, four channels, border kept). The user must
// write configuration via cfg_we/cfg_index/cfg_data only while idle; not enforced.
module texture_channel_content_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // comp_0 [7:0], comp_1 [15:8], comp_2 [23:16], comp_3 [31:24]
  input  logic [tccc_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // class_0 [2:0], class_1 [5:3], class_2 [8:6], class_3 [11:9],
  // solid_0 [19:12], solid_1 [27:20], solid_2 [35:28], solid_3 [43:36], zeros above
  output logic [tccc_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import tccc_pkg::*;

  cfg_t    cfg;
  logic    pix_valid;
  pixel_t  pix;
  logic    advance, is_last;
  result_t result;

  // Configuration registers; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= DIM_W'(1);
      cfg.image_height    <= DIM_W'(1);
      cfg.chan_count      <= CHCNT_W'(NUM_CH);
      cfg.fix_alpha_edges <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[DIM_W-1:0];
        REG_CHAN_COUNT:      cfg.chan_count      <= cfg_data[CHCNT_W-1:0];
        REG_FIX_ALPHA_EDGES: cfg.fix_alpha_edges <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A pixel moves on unless it closes an image and the result slot is full and not being taken.
  assign advance  = pix_valid && (!is_last || !m_tvalid || m_tready);
  assign s_tready = !pix_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      pix <= s_tdata;
    end
  end

  tccc_stats u_stats (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pixel   (pix),
    .cfg     (cfg),
    .is_last (is_last),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && is_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_last) begin
      m_tdata <= {{(OUT_DATA_W - OUT_BITS){1'b0}}, result};
    end
  end

endmodule

// ===== rtl/tccc_checker.sv =====
module tccc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tccc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tccc_pkg::*;

  // A held result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Every class code is one of the five defined classes.
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= CLS_VARYING) && (m_tdata[5:3] <= CLS_VARYING) &&
                 (m_tdata[8:6] <= CLS_VARYING) && (m_tdata[11:9] <= CLS_VARYING))
    else $error("class code out of range");

  // The input side only stalls behind an occupied, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // A new result follows an accepted pixel through the input register and the result register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without a pixel two cycles earlier");

  // Nothing is presented right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind texture_channel_content_classifier tccc_checker u_tccc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
